// File: hw/rtl/bfsa_pkg.sv
// Shared types and codes for the best-fit segment allocator.
// Used by bfsa_cell and best_fit_segment_allocator; no dependencies.
package bfsa_pkg;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Managed units after reset.
	localparam int RESET_UNITS = 4096;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	// Operation broadcast to every cell: init on a size write, the rest during the update cycle.
	typedef struct packed {
		logic init;       // reinitialize the table
		logic take;       // chosen entry becomes allocated
		logic trim;       // chosen entry gets a new last unit
		logic release_e;  // chosen entry becomes free
		logic make_rem;   // remainder slot becomes a free segment
	} upd_t;

endpackage

// File: hw/rtl/best_fit_segment_allocator.sv
// Best-fit segment allocator: top level with controller and the row of cells.
// Depends on bfsa_pkg and bfsa_cell.
// Each item scans the whole table (S_SCAN); S_UPD then applies the update and
// S_OUT loads the output register once it is empty. One item is in flight at a
// time; the next input transfer can follow once the controller is back in idle.
// Reset and a size write leave one free segment covering all memory (4096 units
// after reset); both take effect at once, no sweep.
module best_fit_segment_allocator
	import bfsa_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int ADDR_BITS   = 16,
	parameter int OWNER_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  owner_id,
	input  logic [16:0] request_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] seg_start,
	output logic [15:0] seg_end,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data
);

	localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int LENW = ADDR_BITS + 1;

	state_t state_q;
	logic [CNTW-1:0] cnt_q;
	logic kind_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [LENW-1:0] req_q;

	logic best_ok_q, slot_ok_q, hit_ok_q;
	logic [IDXW-1:0] best_q, slot_q, hit_q;
	logic [LENW-1:0] best_len_q;
	logic [ADDR_BITS-1:0] best_first_q, best_last_q, hit_first_q, hit_last_q;

	logic [1:0] status_q;
	logic [15:0] start_q, end_q;
	logic [1:0] out_status_q;
	logic [15:0] out_start_q, out_end_q;
	logic out_valid_q;

	logic [TABLE_DEPTH-1:0] v, f;
	logic [OWNER_BITS-1:0] ow [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] fs [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] ls [TABLE_DEPTH];

	logic shift;
	upd_t upd;
	logic [ADDR_BITS-1:0] init_last, split, new_last;
	logic [LENW-1:0] len0, cfg_sat;
	logic [IDXW-1:0] idx;
	logic split_case;

	assign idx = cnt_q[IDXW-1:0];
	assign shift = (state_q == S_SCAN);
	// The table is rebuilt in the same cycle as the size write, from the new size.
	assign init_last = ADDR_BITS'(cfg_sat - 1'b1);
	assign len0 = (ls[0] < fs[0]) ? '0 : LENW'({1'b0, ls[0]} - {1'b0, fs[0]} + 1'b1);
	assign split = ADDR_BITS'({1'b0, best_first_q} + req_q);
	assign new_last = split - 1'b1;
	assign split_case = best_ok_q && (best_len_q != req_q);

	always_comb begin
		cfg_sat = (cfg_data == '0) ? LENW'(1) : LENW'(cfg_data);
		if ({15'd0, cfg_data} > (32'd1 << ADDR_BITS))
			cfg_sat = LENW'(32'd1 << ADDR_BITS);
	end

	always_comb begin
		upd = '0;
		upd.init = cfg_we;
		if (state_q == S_UPD) begin
			if (kind_q == KIND_ALLOC) begin
				upd.take = best_ok_q && (!split_case || slot_ok_q);
				upd.trim = split_case && slot_ok_q;
				upd.make_rem = split_case && slot_ok_q;
			end else begin
				upd.release_e = hit_ok_q;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			localparam int P = (g + 1) % TABLE_DEPTH;
			bfsa_cell #(.ADDR_BITS(ADDR_BITS), .OWNER_BITS(OWNER_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.is_first(g == 0),
				.sel(best_q == IDXW'(g) && kind_q == KIND_ALLOC ||
					hit_q == IDXW'(g) && kind_q == KIND_FREE),
				.slot(slot_q == IDXW'(g)),
				.upd(upd), .init_last(init_last), .new_owner(owner_q),
				.new_last(new_last), .rem_first(split), .rem_last(best_last_q),
				.prev_valid(v[P]), .prev_free(f[P]), .prev_owner(ow[P]),
				.prev_first(fs[P]), .prev_last(ls[P]),
				.valid_q(v[g]), .free_q(f[g]), .owner_q(ow[g]),
				.first_q(fs[g]), .last_q(ls[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			best_ok_q <= 1'b0;
			slot_ok_q <= 1'b0;
			hit_ok_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_SCAN;
						cnt_q <= '0;
						best_ok_q <= 1'b0;
						slot_ok_q <= 1'b0;
						hit_ok_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// Entry idx sits at cell 0 this cycle.
					if (v[0] && f[0] && req_q != '0 && len0 >= req_q &&
						(!best_ok_q || len0 < best_len_q)) begin
						best_ok_q <= 1'b1;
						best_q <= idx;
						best_len_q <= len0;
						best_first_q <= fs[0];
						best_last_q <= ls[0];
					end
					if (!v[0] && !slot_ok_q) begin
						slot_ok_q <= 1'b1;
						slot_q <= idx;
					end
					if (v[0] && !f[0] && ow[0] == owner_q && !hit_ok_q) begin
						hit_ok_q <= 1'b1;
						hit_q <= idx;
						hit_first_q <= fs[0];
						hit_last_q <= ls[0];
					end
					if (cnt_q == CNTW'(TABLE_DEPTH - 1))
						state_q <= S_UPD;
					cnt_q <= cnt_q + 1'b1;
				end
				S_UPD: begin
					state_q <= S_OUT;
					if (kind_q == KIND_ALLOC) begin
						if (!best_ok_q) begin
							status_q <= ST_NO_FIT;
							start_q <= '0;
							end_q <= '0;
						end else if (split_case && !slot_ok_q) begin
							status_q <= ST_FULL;
							start_q <= '0;
							end_q <= '0;
						end else begin
							status_q <= ST_OK;
							start_q <= 16'(best_first_q);
							end_q <= split_case ? 16'(new_last) : 16'(best_last_q);
						end
					end else if (!hit_ok_q) begin
						status_q <= ST_NOT_FOUND;
						start_q <= '0;
						end_q <= '0;
					end else begin
						status_q <= ST_OK;
						start_q <= 16'(hit_first_q);
						end_q <= 16'(hit_last_q);
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_status_q <= status_q;
						out_start_q <= start_q;
						out_end_q <= end_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			owner_q <= OWNER_BITS'(owner_id);
			req_q <= LENW'(request_size);
		end
	end

	// Next item may enter while the previous result waits in the output register.
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign seg_start = out_start_q;
	assign seg_end = out_end_q;

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_UPD) |-> cnt_q == CNTW'(TABLE_DEPTH))
		else $error("scan length wrong");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(seg_start))
		else $error("result changed while stalled");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> seg_start == '0 && seg_end == '0)
		else $error("error result carries bounds");
	a_one_live: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_SCAN)
		else $error("transfer did not start scan");

endmodule

// File: hw/rtl/bfsa_cell.sv
// One table entry of the segment allocator.
// Depends on bfsa_pkg. During a scan the row of cells rotates its contents by
// one place per cycle, so the controller sees every entry at cell 0.
module bfsa_cell
	import bfsa_pkg::*;
#(
	parameter int ADDR_BITS  = 16,
	parameter int OWNER_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic                  is_first,
	input  logic                  sel,
	input  logic                  slot,
	input  upd_t                  upd,
	input  logic [ADDR_BITS-1:0]  init_last,
	input  logic [OWNER_BITS-1:0] new_owner,
	input  logic [ADDR_BITS-1:0]  new_last,
	input  logic [ADDR_BITS-1:0]  rem_first,
	input  logic [ADDR_BITS-1:0]  rem_last,
	input  logic                  prev_valid,
	input  logic                  prev_free,
	input  logic [OWNER_BITS-1:0] prev_owner,
	input  logic [ADDR_BITS-1:0]  prev_first,
	input  logic [ADDR_BITS-1:0]  prev_last,
	output logic                  valid_q,
	output logic                  free_q,
	output logic [OWNER_BITS-1:0] owner_q,
	output logic [ADDR_BITS-1:0]  first_q,
	output logic [ADDR_BITS-1:0]  last_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= is_first;
			free_q  <= is_first;
			owner_q <= '0;
			first_q <= '0;
			last_q  <= is_first ? ADDR_BITS'(RESET_UNITS - 1) : '0;
		end else if (upd.init) begin
			valid_q <= is_first;
			free_q  <= is_first;
			owner_q <= '0;
			first_q <= '0;
			last_q  <= is_first ? init_last : '0;
		end else if (shift) begin
			valid_q <= prev_valid;
			free_q  <= prev_free;
			owner_q <= prev_owner;
			first_q <= prev_first;
			last_q  <= prev_last;
		end else begin
			if (sel && upd.take) begin
				free_q  <= 1'b0;
				owner_q <= new_owner;
			end
			if (sel && upd.trim)
				last_q <= new_last;
			if (sel && upd.release_e)
				free_q <= 1'b1;
			if (slot && upd.make_rem) begin
				valid_q <= 1'b1;
				free_q  <= 1'b1;
				owner_q <= '0;
				first_q <= rem_first;
				last_q  <= rem_last;
			end
		end
	end

endmodule

// File: tb/tb_best_fit_segment_allocator.sv
// Self-checking testbench for best_fit_segment_allocator: predicts each result
// from its own copy of the segment table. Depends on bfsa_pkg and the RTL.
module tb_best_fit_segment_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import bfsa_pkg::*;

	localparam int DEPTH = 32;
	localparam int LATENCY = DEPTH + 3;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] seg_start;
		logic [15:0] seg_end;
	} seg_result_t;

	class seg_table_scoreboard;
		bit          used [DEPTH];
		bit          avail [DEPTH];
		logic [7:0]  owner [DEPTH];
		logic [15:0] first [DEPTH];
		logic [15:0] last [DEPTH];
		seg_result_t pending [$];
		int          errors;
		int          checked;

		function void load_size(logic [16:0] value);
			if (value == 0)
				value = 1;
			if (value > 17'd65536)
				value = 17'd65536;
			for (int i = 0; i < DEPTH; i++) begin
				used[i] = 0;
				avail[i] = 0;
				owner[i] = '0;
				first[i] = '0;
				last[i] = '0;
			end
			used[0] = 1;
			avail[0] = 1;
			last[0] = 16'(value - 1);
		endfunction

		function void note_transfer(logic k, logic [7:0] id, logic [16:0] req);
			seg_result_t r;
			int best;
			int slot;
			logic [16:0] best_len;
			logic [16:0] len;
			logic [15:0] split;
			r = '0;
			best = -1;
			best_len = '0;
			if (k == KIND_ALLOC) begin
				if (req != 0) begin
					for (int i = 0; i < DEPTH; i++) begin
						if (used[i] && avail[i]) begin
							len = (last[i] < first[i]) ? 17'd0 :
								17'(last[i]) - 17'(first[i]) + 17'd1;
							if (len >= req && (best < 0 || len < best_len)) begin
								best = i;
								best_len = len;
							end
						end
					end
				end
				if (best < 0) begin
					r.status = ST_NO_FIT;
				end else if (best_len == req) begin
					avail[best] = 0;
					owner[best] = id;
					r.seg_start = first[best];
					r.seg_end = last[best];
				end else begin
					slot = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!used[i])
							slot = i;
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						split = first[best] + req[15:0];
						used[slot] = 1;
						avail[slot] = 1;
						owner[slot] = '0;
						first[slot] = split;
						last[slot] = last[best];
						avail[best] = 0;
						owner[best] = id;
						last[best] = split - 16'd1;
						r.seg_start = first[best];
						r.seg_end = last[best];
					end
				end
			end else begin
				best = -1;
				for (int i = DEPTH - 1; i >= 0; i--)
					if (used[i] && !avail[i] && owner[i] == id)
						best = i;
				if (best < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					avail[best] = 1;
					r.seg_start = first[best];
					r.seg_end = last[best];
				end
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(seg_result_t got);
			seg_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d start=%0d end=%0d",
					$time, got.status, got.seg_start, got.seg_end);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.seg_start !== want.seg_start) begin
				$display("%0t: seg_start expected %0d actual %0d", $time, want.seg_start,
					got.seg_start);
				errors++;
			end
			if (got.seg_end !== want.seg_end) begin
				$display("%0t: seg_end expected %0d actual %0d", $time, want.seg_end,
					got.seg_end);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  owner_id;
	logic [16:0] request_size;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] seg_start;
	logic [15:0] seg_end;
	logic        cfg_we;
	logic [16:0] cfg_data;

	seg_table_scoreboard seg_sb;
	int  idle_cycles;
	int  sent;
	bit  hold_off;
	int  sizes_seen;

	best_fit_segment_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .owner_id(owner_id), .request_size(request_size),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .seg_start(seg_start), .seg_end(seg_end),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Valid stays high across a burst; it drops only for a gap or a drain.
	task automatic send_item(logic k, logic [7:0] id, logic [16:0] req);
		int gap;
		// Random gaps between bursts.
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		owner_id <= id;
		request_size <= req;
		do @(posedge clk); while (!in_ready);
		seg_sb.note_transfer(k, id, req);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (seg_sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_size(logic [16:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		seg_sb.load_size(value);
		sizes_seen++;
	endtask

	// Mostly well-formed alloc/free traffic among a small set of owners.
	task automatic random_phase(int count, int max_req);
		logic k;
		logic [7:0] id;
		logic [16:0] req;
		for (int n = 0; n < count; n++) begin
			k = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_FREE;
			id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
			case ($urandom_range(0, 9))
				0: req = 17'($urandom);
				1: req = 17'd0;
				default: req = 17'($urandom_range(1, max_req));
			endcase
			send_item(k, id, req);
		end
	endtask

	// Receiver stall pattern, plus one long hold-off while the sender keeps offering items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0) || (sent % 400 < 100);
		end
	end

	initial begin
		hold_off = 0;
		wait (sent == 300);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			seg_sb.check_result('{status, seg_start, seg_end});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding",
				seg_sb.pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		seg_sb = new();
		seg_sb.load_size(17'd4096);
		arst_n = 0;
		in_valid = 0;
		kind = 0;
		owner_id = 0;
		request_size = 0;
		cfg_we = 0;
		cfg_data = 0;
		idle_cycles = 0;
		sent = 0;
		sizes_seen = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: exact fit, split, no fit, zero size, free, owner miss.
		send_item(KIND_ALLOC, 8'd1, 17'd100);
		send_item(KIND_ALLOC, 8'd255, 17'd0);
		send_item(KIND_ALLOC, 8'd2, 17'd65536);
		send_item(KIND_ALLOC, 8'd2, 17'h1FFFF);
		send_item(KIND_FREE, 8'd7, 17'd0);
		send_item(KIND_FREE, 8'd1, 17'd5);
		send_item(KIND_ALLOC, 8'd3, 17'd100);
		send_item(KIND_ALLOC, 8'd4, 17'd3996);
		send_item(KIND_ALLOC, 8'd5, 17'd1);
		send_item(KIND_FREE, 8'd4, 17'd0);
		send_item(KIND_FREE, 8'd4, 17'd0);
		send_item(KIND_FREE, 8'd255, 17'd0);
		write_size(17'd0);
		send_item(KIND_ALLOC, 8'd9, 17'd1);
		send_item(KIND_ALLOC, 8'd9, 17'd1);
		write_size(17'h1FFFF);
		send_item(KIND_ALLOC, 8'd10, 17'd65536);
		send_item(KIND_FREE, 8'd10, 17'd0);
		// Fill the table with one-unit splits until it reports full.
		for (int n = 0; n < 33; n++)
			send_item(KIND_ALLOC, 8'(n), 17'd1);
		send_item(KIND_ALLOC, 8'd200, 17'd70000);

		write_size(17'd4096);
		random_phase(600, 300);
		write_size(17'd65536);
		random_phase(500, 8000);
		write_size(17'd1);
		random_phase(100, 2);
		write_size(17'($urandom_range(64, 1024)));
		random_phase(500, 64);

		drain();
		$display("Covered %0d items over %0d memory sizes; %0d results checked.",
			sent, sizes_seen + 1, seg_sb.checked);
		if (seg_sb.errors == 0 && seg_sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/bfsa_pkg.sv
hw/rtl/bfsa_cell.sv
hw/rtl/best_fit_segment_allocator.sv
tb/tb_best_fit_segment_allocator.sv
